@@ rtl/multitap_text_entry_core_macros.svh @@
// Assertion macros shared by the text entry RTL.
// Each expects signals named clk and rst in the module that uses it.
`ifndef MULTITAP_TEXT_ENTRY_CORE_MACROS_SVH
`define MULTITAP_TEXT_ENTRY_CORE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define MTE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define MTE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/mte_pkg.sv @@
// ----------------------------------------------------------------------------
// mte_pkg
// Types, register codes and keypad character tables for the text entry core.
// ----------------------------------------------------------------------------
package mte_pkg;

  typedef logic [3:0] key_t;
  typedef logic [2:0] tap_t;
  typedef logic [6:0] char_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_COMMIT_TICKS = 3'd0,
    REG_CHAR_STEP    = 3'd1,
    REG_LINE_LIMIT   = 3'd2,
    REG_LINE_STEP    = 3'd3,
    REG_SCREEN_LIMIT = 3'd4
  } cfg_reg_t;

  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [7:0] COMMIT_TICKS_RST = 8'd10;
  localparam logic [3:0] CHAR_STEP_RST    = 4'd7;
  localparam logic [6:0] LINE_LIMIT_RST   = 7'd120;
  localparam logic [3:0] LINE_STEP_RST    = 4'd8;
  localparam logic [5:0] SCREEN_LIMIT_RST = 6'd60;

  localparam logic [7:0] IDLE_MAX   = 8'd255;
  localparam char_t      SPACE_CHAR = 7'd32;

  // Number of characters on a key; single-character and unknown keys give 1.
  function automatic tap_t key_len(input key_t key);
    tap_t len;
    case (key)
      4'd0:    len = 3'd2;
      4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd8: len = 3'd4;
      4'd7, 4'd9: len = 3'd5;
      default: len = 3'd1;
    endcase
    return len;
  endfunction

  // Character at position idx of a key; idx is below key_len(key).
  function automatic char_t key_char(input key_t key, input tap_t idx);
    logic [7:0] chars [5];
    char_t      ch;
    case (key)
      4'd0:    chars = '{" ", "0", 8'h00, 8'h00, 8'h00};
      4'd1:    chars = '{"1", 8'h00, 8'h00, 8'h00, 8'h00};
      4'd2:    chars = '{"A", "B", "C", "2", 8'h00};
      4'd3:    chars = '{"D", "E", "F", "3", 8'h00};
      4'd4:    chars = '{"G", "H", "I", "4", 8'h00};
      4'd5:    chars = '{"J", "K", "L", "5", 8'h00};
      4'd6:    chars = '{"M", "N", "O", "6", 8'h00};
      4'd7:    chars = '{"P", "Q", "R", "S", "7"};
      4'd8:    chars = '{"T", "U", "V", "8", 8'h00};
      4'd9:    chars = '{"W", "X", "Y", "Z", "9"};
      4'd10:   chars = '{"*", 8'h00, 8'h00, 8'h00, 8'h00};
      4'd11:   chars = '{"#", 8'h00, 8'h00, 8'h00, 8'h00};
      default: chars = '{" ", 8'h00, 8'h00, 8'h00, 8'h00};
    endcase
    if (idx > 3'd4) begin
      ch = chars[0][6:0];
    end else begin
      ch = chars[idx][6:0];
    end
    return ch;
  endfunction

endpackage

@@ rtl/mte_if.sv @@
// ----------------------------------------------------------------------------
// mte_key_if / mte_draw_if
// Valid/ready channels for key and tick items in, draw items out.
// ----------------------------------------------------------------------------
interface mte_key_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [3:0] key_code;

  modport source (output valid, output func, output key_code, input ready);
  modport sink   (input valid, input func, input key_code, output ready);
endinterface

interface mte_draw_if;
  logic       valid;
  logic       ready;
  logic [6:0] char_code;
  logic [6:0] column;
  logic [5:0] row;
  logic       clear_screen;

  modport source (output valid, output char_code, output column, output row,
                  output clear_screen, input ready);
  modport sink   (input valid, input char_code, input column, input row,
                  input clear_screen, output ready);
endinterface

@@ rtl/multitap_text_entry_core.sv @@
// ----------------------------------------------------------------------------
// multitap_text_entry_core
// Multi-tap keypad text entry: keys cycle letters, ticks time out the tap.
// ----------------------------------------------------------------------------
// Path: an accepted key item loads the input register, then moves on to the
// result register when that is empty or draw_out.ready takes its draw item.
// Throughput: one item per cycle unless draw_out.ready stalls the result
// register. Ticks give no draw item. Reset is synchronous: cursor and tap
// state clear, configuration registers return to their defaults.
`include "multitap_text_entry_core_macros.svh"

module multitap_text_entry_core
  import mte_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  mte_key_if.sink               key_in,
  mte_draw_if.source            draw_out
);

  // configuration
  logic [7:0] commit_ticks;
  logic [3:0] char_step;
  logic [6:0] line_limit;
  logic [3:0] line_step;
  logic [5:0] screen_limit;

  // input register
  logic in_valid;
  logic in_func;
  key_t in_key;

  // state
  logic [7:0] cursor_x;
  logic [6:0] cursor_y;
  tap_t       tap_index;
  key_t       previous_key;
  logic       started;
  logic       pending_commit;
  logic [7:0] idle_count;
  logic [7:0] drawn_x;

  // result register
  logic  out_valid;
  char_t out_char;
  logic [6:0] out_column;
  logic [5:0] out_row;
  logic  out_clear;

  // next values
  logic [7:0] cursor_x_next;
  logic [6:0] cursor_y_next;
  tap_t       tap_index_next;
  logic       pending_commit_next;
  logic [7:0] idle_count_next;
  char_t      char_next;
  logic       clear_next;

  logic       fire;
  logic       new_key;
  logic [7:0] cx_step;
  logic [7:0] cx_adv;
  logic [6:0] cy_wrap;
  tap_t       tap_base;
  tap_t       len;
  tap_t       idx;
  tap_t       idx_inc;

  assign fire         = in_valid && (!out_valid || draw_out.ready);
  assign key_in.ready = !in_valid || fire;

  assign draw_out.valid        = out_valid;
  assign draw_out.char_code    = out_char;
  assign draw_out.column       = out_column;
  assign draw_out.row          = out_row;
  assign draw_out.clear_screen = out_clear;

  assign cx_step = cursor_x + {4'd0, char_step};

  always_comb begin
    cursor_x_next       = cursor_x;
    cursor_y_next       = cursor_y;
    tap_index_next      = tap_index;
    pending_commit_next = pending_commit;
    idle_count_next     = idle_count;
    char_next           = SPACE_CHAR;
    clear_next          = 1'b0;
    new_key             = started && (previous_key != in_key);
    cx_adv              = cursor_x;
    cy_wrap             = cursor_y;
    tap_base            = tap_index;
    len                 = key_len(in_key);
    idx                 = 3'd0;
    idx_inc             = 3'd0;
    if (!in_func) begin
      // tick: once idle count reaches commit_ticks, time out the tap cycle and commit the pending advance
      if (idle_count >= commit_ticks) begin
        tap_index_next = 3'd0;
        if (pending_commit) begin
          cursor_x_next       = cx_step;
          pending_commit_next = 1'b0;
        end
      end
      if (idle_count != IDLE_MAX) begin
        idle_count_next = idle_count + 8'd1;
      end
    end else begin
      idle_count_next     = 8'd0;
      pending_commit_next = 1'b1;
      if (new_key) begin
        tap_base = 3'd0;
        if (drawn_x == cursor_x) begin
          cx_adv = cx_step;
        end
      end
      cursor_x_next = cx_adv;
      if (cx_adv >= {1'b0, line_limit}) begin
        cursor_x_next = 8'd0;
        cy_wrap       = cursor_y + {3'd0, line_step};
      end
      cursor_y_next = cy_wrap;
      if (cy_wrap >= {1'b0, screen_limit}) begin
        cursor_x_next = 8'd0;
        cursor_y_next = 7'd0;
        clear_next    = 1'b1;
      end
      idx       = (tap_base >= len) ? 3'd0 : tap_base;
      char_next = key_char(in_key, idx);
      idx_inc   = idx + 3'd1;
      if (len > 3'd1) begin
        tap_index_next = (idx_inc >= len) ? 3'd0 : idx_inc;
      end else begin
        tap_index_next = tap_base;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      commit_ticks <= COMMIT_TICKS_RST;
      char_step    <= CHAR_STEP_RST;
      line_limit   <= LINE_LIMIT_RST;
      line_step    <= LINE_STEP_RST;
      screen_limit <= SCREEN_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COMMIT_TICKS: commit_ticks <= cfg_data[7:0];
        REG_CHAR_STEP:    char_step    <= cfg_data[3:0];
        REG_LINE_LIMIT:   line_limit   <= cfg_data[6:0];
        REG_LINE_STEP:    line_step    <= cfg_data[3:0];
        REG_SCREEN_LIMIT: screen_limit <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid       <= 1'b0;
      out_valid      <= 1'b0;
      cursor_x       <= 8'd0;
      cursor_y       <= 7'd0;
      tap_index      <= 3'd0;
      previous_key   <= '0;
      started        <= 1'b0;
      pending_commit <= 1'b0;
      idle_count     <= 8'd0;
      drawn_x        <= 8'd0;
    end else begin
      if (key_in.ready) begin
        in_valid <= key_in.valid;
      end
      if (fire && in_func) begin
        out_valid <= 1'b1;
      end else if (draw_out.ready) begin
        out_valid <= 1'b0;
      end
      if (fire) begin
        cursor_x       <= cursor_x_next;
        cursor_y       <= cursor_y_next;
        tap_index      <= tap_index_next;
        pending_commit <= pending_commit_next;
        idle_count     <= idle_count_next;
        if (in_func) begin
          started      <= 1'b1;
          previous_key <= in_key;
          drawn_x      <= cursor_x_next;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (key_in.valid && key_in.ready) begin
      in_func <= key_in.func;
      in_key  <= key_in.key_code;
    end
    if (fire && in_func) begin
      out_char   <= char_next;
      out_column <= cursor_x_next[6:0];
      out_row    <= cursor_y_next[5:0];
      out_clear  <= clear_next;
    end
  end

  `MTE_ASSERT_NEXT(a_key_gives_draw, fire && in_func, out_valid, "key item gave no draw item")
  `MTE_ASSERT_NEXT(a_tick_no_draw, fire && !in_func && !out_valid, !out_valid,
                   "tick item produced a draw item")
  `MTE_ASSERT_SAME(a_tap_in_range, 1'b1, tap_index < 3'd5, "tap index out of range")
  `MTE_ASSERT_SAME(a_clear_homes, out_valid && out_clear,
                   out_column == 7'd0 && out_row == 6'd0, "clear without cursor home")
  `MTE_ASSERT_NEXT(a_key_resets_idle, fire && in_func, idle_count == 8'd0,
                   "idle count not cleared by key")

endmodule
